@@ hw/rtl/bab_pkg.sv @@
// Shared definitions for the block allocation bitmap: field widths, op codes,
// register index, defaults, and the command/status structs between controller
// and datapath. No dependencies.
package bab_pkg;

   localparam int unsigned ROW_WIDTH_DEF  = 32;
   localparam int unsigned MAX_BLOCKS_DEF = 1024;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned BLOCK_W = 10;
   localparam int unsigned COUNT_W = 11;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   // shift used for the reciprocal row/position split of 11-bit values
   localparam int unsigned DIV_SHIFT = 18;

   localparam logic [OP_W-1:0] OP_SET   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
   localparam logic [OP_W-1:0] OP_INIT  = 3'd4;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_BLOCK_COUNT = 1'b0;

   typedef struct packed {
      logic load;
      logic div_q;
      logic div_r;
      logic row_update;
      logic scan_run;
      logic sweep_init;
      logic sweep_run;
      logic result_load;
   } bab_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            err;
      logic            scan_done;
      logic            sweep_last;
      logic            out_free;
   } bab_stat_type;

endpackage

@@ hw/rtl/bab_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bab_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   logic [WIDTH-1:0] rdata_in;

   assign rdata_in = mem_ff[raddr];
   assign rdata    = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= rdata_in;
   end

endmodule

@@ hw/rtl/bab_dpath.sv @@
// Datapath of the block allocation bitmap: request registers, row/position
// split, bitmap RAM, scan and sweep counters, result register.
// Depends on bab_pkg and bab_ram.
module bab_dpath import bab_pkg::*; #(
   parameter int unsigned ROW_WIDTH  = ROW_WIDTH_DEF,
   parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  bab_cmd_type        cmd,
   output bab_stat_type       stat,
   input  logic [OP_W-1:0]    req_op,
   input  logic [BLOCK_W-1:0] req_block,
   input  logic [COUNT_W-1:0] active_count,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic               rsp_is_used,
   output logic               rsp_found,
   output logic [BLOCK_W-1:0] rsp_free_block,
   output logic               rsp_error
);

   localparam int unsigned ROW_COUNT = (MAX_BLOCKS + ROW_WIDTH - 1) / ROW_WIDTH;
   localparam int unsigned RIDX_W    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int unsigned RQ_W      = (RIDX_W + 1 > COUNT_W) ? RIDX_W + 1 : COUNT_W;
   localparam int unsigned PW        = $clog2(ROW_WIDTH);
   localparam int unsigned BASE_W    = $clog2(ROW_COUNT * ROW_WIDTH + 1);
   localparam int unsigned FB_W      = (BASE_W > BLOCK_W) ? BASE_W : BLOCK_W;
   localparam int unsigned RECIP     = ((1 << DIV_SHIFT) + ROW_WIDTH - 1) / ROW_WIDTH;
   localparam logic [RIDX_W-1:0] LAST_ROW = RIDX_W'(ROW_COUNT - 1);

   logic [ROW_WIDTH-1:0] ones;
   assign ones = '1;

   // request and split registers
   logic [OP_W-1:0]    op_ff,  op_in;
   logic [COUNT_W-1:0] blk_ff, blk_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               err_ff, err_in;
   logic [RQ_W-1:0]    qb_ff,  qb_in;
   logic [RQ_W-1:0]    qc_ff,  qc_in;
   logic [PW-1:0]      pb_ff,  pb_in;
   logic [PW-1:0]      pc_ff,  pc_in;

   // scan pipeline
   logic [RIDX_W-1:0]  rd_row_ff,     rd_row_in;
   logic [FB_W-1:0]    rd_base_ff,    rd_base_in;
   logic               eval_valid_ff, eval_valid_in;
   logic [RIDX_W-1:0]  eval_row_ff,   eval_row_in;
   logic [FB_W-1:0]    eval_base_ff,  eval_base_in;

   // sweep
   logic [RIDX_W-1:0]  sweep_row_ff, sweep_row_in;
   logic               clear_ff,     clear_in;

   // per-item results and output register
   logic               res_used_ff,  res_used_in;
   logic               res_found_ff, res_found_in;
   logic [BLOCK_W-1:0] res_free_ff,  res_free_in;
   logic               rsp_valid_ff,   rsp_valid_in;
   logic               rsp_used_ff,    rsp_used_in;
   logic               rsp_found_ff,   rsp_found_in;
   logic [BLOCK_W-1:0] rsp_free_ff,    rsp_free_in;
   logic               rsp_error_ff,   rsp_error_in;

   logic [31:0]          prod_b, prod_c, qb_scaled, qc_scaled;
   logic                 ram_we;
   logic [RIDX_W-1:0]    ram_waddr, ram_raddr;
   logic [ROW_WIDTH-1:0] ram_wdata, ram_rdata;
   logic [ROW_WIDTH-1:0] bit_mask, modified, sweep_word, lo_mask, cand, lowest;
   logic [PW-1:0]        idx;
   logic                 hit, scan_done, sweep_last, query_bit, is_write_op;

   // bits at or above the count within a row
   function automatic logic [ROW_WIDTH-1:0] pad_word(input logic [RQ_W-1:0] row,
                                                     input logic [RQ_W-1:0] qc,
                                                     input logic [PW-1:0]   pc);
      logic [ROW_WIDTH-1:0] all_set;
      all_set = '1;
      if (row < qc) begin
         return '0;
      end else if (row == qc) begin
         return all_set << pc;
      end else begin
         return all_set;
      end
   endfunction

   // row = value / ROW_WIDTH by reciprocal, exact for 11-bit values
   assign prod_b    = 32'(blk_ff) * 32'(RECIP);
   assign prod_c    = 32'(cnt_ff) * 32'(RECIP);
   assign qb_scaled = 32'(qb_ff) * 32'(ROW_WIDTH);
   assign qc_scaled = 32'(qc_ff) * 32'(ROW_WIDTH);

   bab_ram #(
      .WIDTH (ROW_WIDTH),
      .DEPTH (ROW_COUNT)
   ) u_rows (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign is_write_op = (op_ff == OP_SET) || (op_ff == OP_CLEAR);
   assign bit_mask    = {{(ROW_WIDTH-1){1'b0}}, 1'b1} << pb_ff;
   assign modified    = (op_ff == OP_SET) ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
   assign query_bit   = |(ram_rdata & bit_mask);
   assign sweep_word  = clear_ff ? '0 : pad_word(RQ_W'(sweep_row_ff), qc_ff, pc_ff);

   assign ram_we    = cmd.sweep_run || (cmd.row_update && is_write_op);
   assign ram_waddr = cmd.sweep_run ? sweep_row_ff : RIDX_W'(qb_ff);
   assign ram_wdata = cmd.sweep_run ? sweep_word : modified;
   assign ram_raddr = cmd.scan_run ? rd_row_ff : RIDX_W'(qb_ff);

   // search evaluation on the row read in the previous cycle
   assign lo_mask = (RQ_W'(eval_row_ff) == qb_ff) ? (ones << pb_ff) : ones;
   assign cand    = ~ram_rdata & ~pad_word(RQ_W'(eval_row_ff), qc_ff, pc_ff) & lo_mask;
   assign lowest  = cand & (~cand + ROW_WIDTH'(1));
   assign hit     = |cand;

   always_comb begin
      idx = '0;
      for (int i = 0; i < ROW_WIDTH; i++) begin
         if (lowest[i]) begin
            idx = idx | PW'(i);
         end
      end
   end

   assign scan_done  = eval_valid_ff &&
                       (hit || (RQ_W'(eval_row_ff) >= qc_ff) || (eval_row_ff == LAST_ROW));
   assign sweep_last = (sweep_row_ff == LAST_ROW);

   always_comb begin
      op_in         = op_ff;
      blk_in        = blk_ff;
      cnt_in        = cnt_ff;
      err_in        = err_ff;
      qb_in         = qb_ff;
      qc_in         = qc_ff;
      pb_in         = pb_ff;
      pc_in         = pc_ff;
      rd_row_in     = rd_row_ff;
      rd_base_in    = rd_base_ff;
      eval_valid_in = eval_valid_ff;
      eval_row_in   = eval_row_ff;
      eval_base_in  = eval_base_ff;
      sweep_row_in  = sweep_row_ff;
      clear_in      = clear_ff;
      res_used_in   = res_used_ff;
      res_found_in  = res_found_ff;
      res_free_in   = res_free_ff;

      if (cmd.load) begin
         op_in        = req_op;
         blk_in       = COUNT_W'(req_block);
         cnt_in       = active_count;
         res_used_in  = 1'b0;
         res_found_in = 1'b0;
         res_free_in  = '0;
      end
      if (cmd.div_q) begin
         qb_in  = RQ_W'(prod_b >> DIV_SHIFT);
         qc_in  = RQ_W'(prod_c >> DIV_SHIFT);
         err_in = (op_ff inside {[OP_SET:OP_FIND]}) && (blk_ff >= cnt_ff);
      end
      if (cmd.div_r) begin
         pb_in         = PW'(32'(blk_ff) - qb_scaled);
         pc_in         = PW'(32'(cnt_ff) - qc_scaled);
         rd_row_in     = RIDX_W'(qb_ff);
         rd_base_in    = FB_W'(qb_scaled);
         eval_valid_in = 1'b0;
      end
      if (cmd.sweep_init) begin
         sweep_row_in = '0;
         clear_in     = 1'b0;
      end
      if (cmd.sweep_run) begin
         sweep_row_in = sweep_last ? '0 : sweep_row_ff + RIDX_W'(1);
      end
      if (cmd.row_update && (op_ff == OP_QUERY)) begin
         res_used_in = query_bit;
      end
      if (cmd.scan_run) begin
         rd_row_in     = (rd_row_ff == LAST_ROW) ? rd_row_ff : rd_row_ff + RIDX_W'(1);
         rd_base_in    = rd_base_ff + FB_W'(ROW_WIDTH);
         eval_valid_in = 1'b1;
         eval_row_in   = rd_row_ff;
         eval_base_in  = rd_base_ff;
         if (scan_done) begin
            res_found_in = hit;
            res_free_in  = hit ? BLOCK_W'(eval_base_ff + FB_W'(idx)) : '0;
         end
      end
   end

   assign rsp_valid_in = cmd.result_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_used_in  = cmd.result_load ? res_used_ff  : rsp_used_ff;
   assign rsp_found_in = cmd.result_load ? res_found_ff : rsp_found_ff;
   assign rsp_free_in  = cmd.result_load ? res_free_ff  : rsp_free_ff;
   assign rsp_error_in = cmd.result_load ? err_ff       : rsp_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_valid_ff <= 1'b0;
         sweep_row_ff  <= '0;
         clear_ff      <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         eval_valid_ff <= eval_valid_in;
         sweep_row_ff  <= sweep_row_in;
         clear_ff      <= clear_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      blk_ff       <= blk_in;
      cnt_ff       <= cnt_in;
      err_ff       <= err_in;
      qb_ff        <= qb_in;
      qc_ff        <= qc_in;
      pb_ff        <= pb_in;
      pc_ff        <= pc_in;
      rd_row_ff    <= rd_row_in;
      rd_base_ff   <= rd_base_in;
      eval_row_ff  <= eval_row_in;
      eval_base_ff <= eval_base_in;
      res_used_ff  <= res_used_in;
      res_found_ff <= res_found_in;
      res_free_ff  <= res_free_in;
      rsp_used_ff  <= rsp_used_in;
      rsp_found_ff <= rsp_found_in;
      rsp_free_ff  <= rsp_free_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign stat.op         = op_ff;
   assign stat.err        = err_ff;
   assign stat.scan_done  = scan_done;
   assign stat.sweep_last = sweep_last;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_used    = rsp_used_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_free_block = rsp_free_ff;
   assign rsp_error      = rsp_error_ff;

endmodule

@@ hw/rtl/bab_ctrl.sv @@
// Controller of the block allocation bitmap: sequences each item through
// split, row access, scan or sweep, and result hand-off. Depends on bab_pkg.
module bab_ctrl import bab_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  bab_stat_type stat,
   output bab_cmd_type  cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DIV1   = 4'd2;
   localparam logic [3:0] S_DIV2   = 4'd3;
   localparam logic [3:0] S_READ   = 4'd4;
   localparam logic [3:0] S_UPDATE = 4'd5;
   localparam logic [3:0] S_SCAN   = 4'd6;
   localparam logic [3:0] S_INIT   = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.sweep_run = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            cmd.div_q = 1'b1;
            state_in  = S_DIV2;
         end
         S_DIV2: begin
            cmd.div_r      = 1'b1;
            cmd.sweep_init = 1'b1;
            if (stat.err) begin
               state_in = S_DONE;
            end else begin
               case (stat.op)
                  OP_SET, OP_CLEAR, OP_QUERY: state_in = S_READ;
                  OP_FIND:                    state_in = S_SCAN;
                  OP_INIT:                    state_in = S_INIT;
                  default:                    state_in = S_DONE;
               endcase
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.row_update = 1'b1;
            state_in       = S_DONE;
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_INIT: begin
            cmd.sweep_run = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/block_allocation_bitmap.sv @@
// Steps: mark used/free and query go through the split, a row read and the row update;
// find free splits, then scans rows (one row per cycle from the start row, up to the count);
// initialise splits, then sweeps the map (one RAM row written per cycle).
// One item in flight; the next is accepted the cycle after the result is loaded.
// Reset: synchronous; a clearing pass writes every row before the first item is
// accepted. Depends on bab_pkg, bab_ctrl, bab_dpath.
module block_allocation_bitmap import bab_pkg::*; #(
   parameter int unsigned ROW_WIDTH  = ROW_WIDTH_DEF,
   parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [BLOCK_W-1:0]    req_block,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_is_used,
   output logic                  rsp_found,
   output logic [BLOCK_W-1:0]    rsp_free_block,
   output logic                  rsp_error,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [COUNT_W-1:0] block_count_ff, block_count_in;
   logic [COUNT_W-1:0] active_count;
   logic               csr_write;
   bab_cmd_type        cmd;
   bab_stat_type       stat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_BLOCK_COUNT);
   assign block_count_in = csr_write ? csr_pwdata[COUNT_W-1:0] : block_count_ff;
   assign csr_prdata = (csr_paddr[2] == REG_BLOCK_COUNT) ? 32'(block_count_ff) : '0;

   // count saturates at the map size
   assign active_count = (32'(block_count_ff) > 32'(MAX_BLOCKS)) ?
                         COUNT_W'(MAX_BLOCKS) : block_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= COUNT_RESET;
      end else begin
         block_count_ff <= block_count_in;
      end
   end

   bab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bab_dpath #(
      .ROW_WIDTH  (ROW_WIDTH),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_op),
      .req_block      (req_block),
      .active_count   (active_count),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_is_used    (rsp_is_used),
      .rsp_found      (rsp_found),
      .rsp_free_block (rsp_free_block),
      .rsp_error      (rsp_error)
   );

endmodule

@@ hw/rtl/bab_checker.sv @@
// Port-level checks for the block allocation bitmap, bound to the top level.
// Depends on bab_pkg and block_allocation_bitmap.
module bab_checker import bab_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_is_used,
   input logic               rsp_found,
   input logic [BLOCK_W-1:0] rsp_free_block,
   input logic               rsp_error
);

   // the map is being cleared right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("item taken during clearing pass");

   // an out-of-range block yields no other result bits
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_found && !rsp_is_used && (rsp_free_block == '0))
      else $error("error result carries other fields");

   // query and find results never mix
   a_query_find_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> !rsp_is_used)
      else $error("found and is_used both set");

   a_free_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_free_block == '0))
      else $error("free_block nonzero without a find hit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind block_allocation_bitmap bab_checker u_bab_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_is_used    (rsp_is_used),
   .rsp_found      (rsp_found),
   .rsp_free_block (rsp_free_block),
   .rsp_error      (rsp_error)
);

@@ bench/block_allocation_bitmap_tb.sv @@
// Self-checking testbench for block_allocation_bitmap: a directed table, then
// random phases at several block counts, checked against a shadow of the map.
// Depends on bab_pkg and the block_allocation_bitmap RTL.
module block_allocation_bitmap_tb;
   import bab_pkg::*;

   // op codes the block leaves unused
   localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
   localparam logic [BLOCK_W-1:0] BLOCK_TOP = '1;
   localparam int unsigned PHASES = 8;
   localparam int unsigned PHASE_ITEMS = 150;
   localparam int unsigned DIRECTED_LEN = 27;

   typedef struct packed {
      logic               is_used;
      logic               found;
      logic [BLOCK_W-1:0] free_block;
      logic               error;
   } bab_result_type;

   typedef struct packed {
      logic [COUNT_W-1:0] cnt;
      logic [OP_W-1:0]    op;
      logic [BLOCK_W-1:0] blk;
      logic               typed;
      bab_result_type     res;
   } dir_row_type;

   localparam bab_result_type NO_RESULT = '0;
   localparam bab_result_type OUT_OF_RANGE = '{1'b0, 1'b0, 10'd0, 1'b1};
   localparam bab_result_type MARKED_USED = '{1'b1, 1'b0, 10'd0, 1'b0};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op;
   logic [BLOCK_W-1:0]    req_block;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_is_used;
   logic                  rsp_found;
   logic [BLOCK_W-1:0]    rsp_free_block;
   logic                  rsp_error;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // shadow state
   logic [MAX_BLOCKS_DEF-1:0] shadow_map;
   logic [COUNT_W-1:0]        shadow_count;
   bab_result_type            expected_results[$];
   int unsigned               mismatches;
   int unsigned               sender_idle_pct;
   int unsigned               receiver_stall_pct;
   int unsigned               hold_left;

   dir_row_type directed_rows [DIRECTED_LEN] = '{
      '{11'd1024, OP_QUERY,  10'd0,    1'b1, NO_RESULT},
      '{11'd1024, OP_QUERY,  10'd1023, 1'b1, NO_RESULT},
      '{11'd1024, OP_SET,    10'd0,    1'b1, NO_RESULT},
      '{11'd1024, OP_QUERY,  10'd0,    1'b1, MARKED_USED},
      '{11'd1024, OP_FIND,   10'd0,    1'b1, '{1'b0, 1'b1, 10'd1, 1'b0}},
      '{11'd1024, OP_SET,    10'd1023, 1'b1, NO_RESULT},
      '{11'd1024, OP_FIND,   10'd1023, 1'b1, NO_RESULT},
      '{11'd1024, OP_FIND,   10'd31,   1'b0, NO_RESULT},
      '{11'd1024, OP_CLEAR,  10'd0,    1'b1, NO_RESULT},
      '{11'd1024, OP_SPARE5, 10'd1023, 1'b1, NO_RESULT},
      '{11'd1024, OP_SPARE6, 10'd0,    1'b1, NO_RESULT},
      '{11'd1024, OP_SPARE7, 10'd682,  1'b1, NO_RESULT},
      '{11'd40,   OP_INIT,   10'd341,  1'b1, NO_RESULT},
      '{11'd40,   OP_QUERY,  10'd40,   1'b1, OUT_OF_RANGE},
      '{11'd40,   OP_QUERY,  10'd39,   1'b1, NO_RESULT},
      '{11'd40,   OP_SET,    10'd31,   1'b0, NO_RESULT},
      '{11'd40,   OP_FIND,   10'd31,   1'b0, NO_RESULT},
      '{11'd40,   OP_FIND,   10'd40,   1'b1, OUT_OF_RANGE},
      '{11'd0,    OP_QUERY,  10'd0,    1'b1, OUT_OF_RANGE},
      '{11'd0,    OP_FIND,   10'd0,    1'b1, OUT_OF_RANGE},
      '{11'd0,    OP_INIT,   10'd1023, 1'b1, NO_RESULT},
      '{11'd1,    OP_QUERY,  10'd0,    1'b0, NO_RESULT},
      '{11'd1,    OP_INIT,   10'd0,    1'b1, NO_RESULT},
      '{11'd1,    OP_FIND,   10'd0,    1'b1, '{1'b0, 1'b1, 10'd0, 1'b0}},
      '{11'd2047, OP_QUERY,  10'd1023, 1'b0, NO_RESULT},
      '{11'd2047, OP_CLEAR,  10'd1000, 1'b0, NO_RESULT},
      '{11'd2047, OP_FIND,   10'd5,    1'b0, NO_RESULT}
   };

   block_allocation_bitmap dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_block      (req_block),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_used    (rsp_is_used),
      .rsp_found      (rsp_found),
      .rsp_free_block (rsp_free_block),
      .rsp_error      (rsp_error),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int unsigned active_blocks();
      return (shadow_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : shadow_count;
   endfunction

   // applies one request to the shadow map and returns what the block must answer
   function automatic bab_result_type apply_to_map(logic [OP_W-1:0] op,
                                                   logic [BLOCK_W-1:0] blk);
      bab_result_type res;
      int unsigned cnt;
      int unsigned b;
      res = NO_RESULT;
      cnt = active_blocks();
      if (op <= OP_FIND && blk >= cnt) begin
         res.error = 1'b1;
      end else begin
         case (op)
            OP_SET: begin
               shadow_map[blk] = 1'b1;
            end
            OP_CLEAR: begin
               shadow_map[blk] = 1'b0;
            end
            OP_QUERY: begin
               res.is_used = shadow_map[blk];
            end
            OP_FIND: begin
               for (b = blk; b < cnt && !res.found; b++) begin
                  if (!shadow_map[b]) begin
                     res.found = 1'b1;
                     res.free_block = BLOCK_W'(b);
                  end
               end
            end
            OP_INIT: begin
               // padding past the count reads as used
               for (b = 0; b < MAX_BLOCKS_DEF; b++) begin
                  shadow_map[b] = (b >= cnt);
               end
            end
            default: begin
            end
         endcase
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      if (mismatches < 40) begin
         $display("mismatch %s: got %0d, expected %0d", what, got, want);
      end
      mismatches++;
   endtask

   // result checker
   always @(posedge clock) begin
      bab_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            flag_mismatch("unexpected item, count", 1, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_is_used !== want.is_used) begin
               flag_mismatch("is_used", rsp_is_used, want.is_used);
            end
            if (rsp_found !== want.found) begin
               flag_mismatch("found", rsp_found, want.found);
            end
            if (rsp_free_block !== want.free_block) begin
               flag_mismatch("free_block", rsp_free_block, want.free_block);
            end
            if (rsp_error !== want.error) begin
               flag_mismatch("error", rsp_error, want.error);
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   task automatic issue_request(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] blk,
                                input logic typed, input bab_result_type given);
      bab_result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_block <= blk;
      do @(posedge clock); while (!req_ready);
      predicted = apply_to_map(op, blk);
      expected_results.push_back(typed ? given : predicted);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_block_count(input logic [COUNT_W-1:0] value);
      logic [31:0] filler;
      filler = $urandom;
      wait_for_results();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(4 * REG_BLOCK_COUNT);
      csr_pwdata <= {filler[31:COUNT_W], value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      shadow_count = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[COUNT_W-1:0] !== value) begin
         flag_mismatch("block_count readback", csr_prdata[COUNT_W-1:0], value);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic random_request();
      logic [OP_W-1:0]    op;
      logic [BLOCK_W-1:0] blk;
      int unsigned        pick;
      int unsigned        cnt;
      pick = $urandom_range(99);
      cnt = active_blocks();
      if (pick < 26) op = OP_SET;
      else if (pick < 46) op = OP_CLEAR;
      else if (pick < 64) op = OP_QUERY;
      else if (pick < 90) op = OP_FIND;
      else if (pick < 93) op = OP_INIT;
      else op = OP_W'($urandom_range(OP_SPARE7, OP_SPARE5));
      // mostly in range, the rest anywhere (out of range where the count allows)
      if (cnt > 0 && $urandom_range(99) < 88) begin
         blk = BLOCK_W'($urandom_range(cnt - 1));
      end else begin
         blk = BLOCK_W'($urandom_range(BLOCK_TOP));
      end
      issue_request(op, blk, 1'b0, NO_RESULT);
   endtask

   initial begin
      logic [COUNT_W-1:0] phase_count [PHASES];
      int unsigned        i;
      int unsigned        p;
      phase_count = '{11'd1024, 11'd37, 11'd2047, 11'd1, 11'd700, 11'd0, 11'd1025, 11'd1};
      phase_count[PHASES-1] = COUNT_W'($urandom_range(1024, 1));
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_SET;
      req_block = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      shadow_map = '0;
      shadow_count = COUNT_RESET;
      mismatches = 0;
      hold_left = 0;
      sender_idle_pct = 11;
      receiver_stall_pct = 83;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_LEN; i++) begin
         if (directed_rows[i].cnt != shadow_count) begin
            set_block_count(directed_rows[i].cnt);
         end
         issue_request(directed_rows[i].op, directed_rows[i].blk,
                       directed_rows[i].typed, directed_rows[i].res);
      end

      for (p = 0; p < PHASES; p++) begin
         if (p == 3) begin
            sender_idle_pct = 83;
            receiver_stall_pct = 11;
         end else if (p == 6) begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         set_block_count(phase_count[p]);
         // a fresh map with its padding is the usual start of a phase
         if ($urandom_range(9) != 0) begin
            issue_request(OP_INIT, BLOCK_W'($urandom_range(BLOCK_TOP)), 1'b0, NO_RESULT);
         end
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 20) hold_left = 400;
            if (p == 4 && i == 75) wait_for_results();
            random_request();
         end
      end

      wait_for_results();
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
